### rtl/dpwp_pkg.sv
// Shared types and constants for the depth pixel to world point block.
package dpwp_pkg;

  localparam int IN_W        = 120;
  localparam int OUT_W       = 120;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_W       = 32;
  localparam int POSE_N      = 12;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] POSE_ONE = 32'h4000_0000;

  localparam logic [31:0] RST_INV_FX = 32'd5974906;
  localparam logic [31:0] RST_INV_FY = 32'd5974906;
  localparam logic [23:0] RST_CX     = 24'd155441;
  localparam logic [23:0] RST_CY     = 24'd47415;
  localparam logic [23:0] RST_CUTOFF = 24'd983040;

  typedef enum logic [0:0] {
    OP_POSE  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_INV_FX = 3'd0,
    REG_INV_FY = 3'd1,
    REG_CX     = 3'd2,
    REG_CY     = 3'd3,
    REG_CUTOFF = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] inv_fx;
    logic [31:0] inv_fy;
    logic [23:0] cx;
    logic [23:0] cy;
    logic [23:0] cutoff;
  } cfg_t;

  typedef struct packed {
    op_t                kind;
    logic [3:0]         pose_idx;
    logic signed [31:0] pose_value;
    logic [15:0]        column;
    logic [15:0]        row;
    logic [23:0]        depth;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } item_t;

endpackage

### rtl/dpwp_front.sv
// Front end: unpacks input words, drops unusable items and pushes the rest.
module dpwp_front (
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [dpwp_pkg::IN_W-1:0]  s_tdata,
  input  logic [0:0]                 s_tuser,
  input  logic [23:0]                cutoff,
  input  logic                       q_full,
  output logic                       q_push,
  output dpwp_pkg::item_t            q_item
);

  logic nan;
  logic keep;

  always_comb begin
    q_item.kind       = dpwp_pkg::op_t'(s_tuser[0]);
    q_item.pose_idx   = s_tdata[3:0];
    q_item.pose_value = s_tdata[35:4];
    q_item.column     = s_tdata[51:36];
    q_item.row        = s_tdata[67:52];
    q_item.depth      = s_tdata[91:68];
    q_item.blue       = s_tdata[100:93];
    q_item.green      = s_tdata[108:101];
    q_item.red        = s_tdata[116:109];
    nan               = s_tdata[92];
    if (q_item.kind == dpwp_pkg::OP_POSE) begin
      keep = (q_item.pose_idx < 4'(dpwp_pkg::POSE_N));
    end else begin
      keep = !nan && (q_item.depth != 24'd0) && (q_item.depth < cutoff);
    end
  end

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full && keep;

endmodule

### rtl/dpwp_fifo.sv
// Short queue that decouples the front end from the arithmetic pipeline.
module dpwp_fifo #(
  parameter int DEPTH = dpwp_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dpwp_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output dpwp_pkg::item_t dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dpwp_pkg::item_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    do_pop && !do_push |=> count == $past(count) - 1'b1)
    else $error("queue count did not shrink on pop");

endmodule

### rtl/dpwp_back.sv
// Back end: back-projection, rigid pose transform and saturated output word.
module dpwp_back (
  input  logic                       clk,
  input  logic                       rst,
  input  dpwp_pkg::cfg_t             cfg,
  input  logic                       q_valid,
  input  dpwp_pkg::item_t            q_item,
  output logic                       q_pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [dpwp_pkg::OUT_W-1:0] m_tdata
);

  logic adv;

  // Stage A: signed pixel offsets from the principal point.
  logic            a_v;
  dpwp_pkg::item_t a_item;
  logic [24:0]     a_mx, a_my;
  logic            a_nx, a_ny;
  logic [25:0]     du, dv, du_n, dv_n;

  // Stage B: offset times depth.
  logic            b_v;
  dpwp_pkg::item_t b_item;
  logic [48:0]     b_tx, b_ty;
  logic            b_nx, b_ny;

  // Stage C: partial products with the reciprocal focal lengths.
  logic            c_v;
  dpwp_pkg::item_t c_item;
  logic [56:0]     c_lx, c_ly;
  logic [55:0]     c_hx, c_hy;
  logic            c_nx, c_ny;

  // Stage D: rounded camera coordinates.
  logic            d_v;
  dpwp_pkg::item_t d_item;
  logic [41:0]     d_mx, d_my;
  logic            d_nx, d_ny;
  logic [80:0]     sx, sy;

  // Stage E: pose store and rotation partial products.
  logic [31:0]     pose [dpwp_pkg::POSE_N];
  logic            e_v;
  logic [7:0]      e_blue, e_green, e_red;
  logic [52:0]     e_pl [9];
  logic [52:0]     e_ph [9];
  logic            e_neg [9];
  logic [31:0]     e_t [3];
  logic [41:0]     cm [3];
  logic            cn [3];
  logic [31:0]     rm [9];

  // Stage F: rounded signed rotation terms.
  logic               f_v;
  logic [7:0]         f_blue, f_green, f_red;
  logic signed [45:0] f_term [9];
  logic [31:0]        f_t [3];
  logic [73:0]        ps [9];

  logic signed [47:0] acc [3];
  logic [31:0]        sat [3];

  assign adv   = !m_tvalid || m_tready;
  assign q_pop = q_valid && adv;

  always_comb begin
    du   = {2'b00, q_item.column, 8'h00} - {2'b00, cfg.cx};
    dv   = {2'b00, q_item.row, 8'h00} - {2'b00, cfg.cy};
    du_n = 26'd0 - du;
    dv_n = 26'd0 - dv;
  end

  always_comb begin
    sx = {c_hx, 25'd0} + 81'(c_lx) + (81'(1) << 39);
    sy = {c_hy, 25'd0} + 81'(c_ly) + (81'(1) << 39);
  end

  always_comb begin
    cm[0] = d_mx;
    cm[1] = d_my;
    cm[2] = 42'(d_item.depth);
    cn[0] = d_nx;
    cn[1] = d_ny;
    cn[2] = 1'b0;
    for (int k = 0; k < 9; k++) begin
      rm[k] = pose[k][31] ? 32'd0 - pose[k] : pose[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ps[k] = {e_ph[k], 21'd0} + 74'(e_pl[k]) + (74'(1) << 29);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 48'(signed'(f_t[i])) + 48'(f_term[3*i]) + 48'(f_term[3*i+1])
             + 48'(f_term[3*i+2]);
      if (!acc[i][47] && (acc[i][46:31] != 16'h0000)) begin
        sat[i] = 32'h7FFF_FFFF;
      end else if (acc[i][47] && (acc[i][46:31] != 16'hFFFF)) begin
        sat[i] = 32'h8000_0000;
      end else begin
        sat[i] = acc[i][31:0];
      end
    end
  end

  // Control: every stage moves together when the output register can take a word.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v      <= 1'b0;
      b_v      <= 1'b0;
      c_v      <= 1'b0;
      d_v      <= 1'b0;
      e_v      <= 1'b0;
      f_v      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      a_v      <= q_pop;
      b_v      <= a_v;
      c_v      <= b_v;
      d_v      <= c_v;
      e_v      <= d_v && (d_item.kind == dpwp_pkg::OP_PIXEL);
      f_v      <= e_v;
      m_tvalid <= f_v;
    end
  end

  // Pose words are written in stream order at the stage that reads them.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < dpwp_pkg::POSE_N; k++) begin
        pose[k] <= (k == 0 || k == 4 || k == 8) ? dpwp_pkg::POSE_ONE : 32'd0;
      end
    end else if (adv && d_v && (d_item.kind == dpwp_pkg::OP_POSE)) begin
      pose[d_item.pose_idx] <= d_item.pose_value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item <= q_item;
      a_nx   <= du[25];
      a_ny   <= dv[25];
      a_mx   <= du[25] ? du_n[24:0] : du[24:0];
      a_my   <= dv[25] ? dv_n[24:0] : dv[24:0];

      b_item <= a_item;
      b_nx   <= a_nx;
      b_ny   <= a_ny;
      b_tx   <= 49'(a_mx) * 49'(a_item.depth);
      b_ty   <= 49'(a_my) * 49'(a_item.depth);

      c_item <= b_item;
      c_nx   <= b_nx;
      c_ny   <= b_ny;
      c_lx   <= 57'(b_tx[24:0]) * 57'(cfg.inv_fx);
      c_hx   <= 56'(b_tx[48:25]) * 56'(cfg.inv_fx);
      c_ly   <= 57'(b_ty[24:0]) * 57'(cfg.inv_fy);
      c_hy   <= 56'(b_ty[48:25]) * 56'(cfg.inv_fy);

      d_item <= c_item;
      d_nx   <= c_nx;
      d_ny   <= c_ny;
      d_mx   <= {1'b0, sx[80:40]};
      d_my   <= {1'b0, sy[80:40]};

      e_blue  <= d_item.blue;
      e_green <= d_item.green;
      e_red   <= d_item.red;
      for (int i = 0; i < 3; i++) begin
        e_t[i] <= pose[9 + i];
        for (int j = 0; j < 3; j++) begin
          e_pl[3*i+j]  <= 53'(cm[j][20:0]) * 53'(rm[3*i+j]);
          e_ph[3*i+j]  <= 53'(cm[j][41:21]) * 53'(rm[3*i+j]);
          e_neg[3*i+j] <= pose[3*i+j][31] ^ cn[j];
        end
      end

      f_blue  <= e_blue;
      f_green <= e_green;
      f_red   <= e_red;
      for (int k = 0; k < 9; k++) begin
        f_term[k] <= e_neg[k] ? -signed'({2'b00, ps[k][73:30]})
                              : signed'({2'b00, ps[k][73:30]});
      end
      for (int i = 0; i < 3; i++) begin
        f_t[i] <= e_t[i];
      end

      m_tdata <= {f_red, f_green, f_blue, sat[2], sat[1], sat[0]};
    end
  end

endmodule

### rtl/depth_pixel_to_world_point.sv
// Top level of the depth pixel to world point block.
//
// Input words arrive on s_tvalid/s_tready/s_tdata with the opcode in s_tuser.
// A pose word (opcode 0) updates one of twelve pose words; a pixel word
// (opcode 1) is dropped when its depth is flagged NaN, is zero or is at or
// above the cutoff, and otherwise yields one world point word on
// m_tvalid/m_tready/m_tdata carrying the pixel colour.
// Intrinsics and cutoff are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, as the block does not enforce
// it. Indexes above four are ignored. Throughput is one word per cycle while
// the receiver is ready. A point passes the queue and the pipeline registers
// for pixel offsets, offset times depth, focal multiplies, camera coordinates,
// rotation multiplies, rotation terms and the output word (saturated final sum).
// When the receiver stalls the pipeline freezes, the queue keeps filling and
// s_tready falls only once the queue is full.
// Reset restores the default intrinsics, an identity rotation and zero
// translation, and empties the queue and pipeline.
module depth_pixel_to_world_point #(
  parameter int QUEUE_DEPTH = dpwp_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pose_index, pose_value, column, row, depth, depth_is_nan,
  // blue_in, green_in, red_in, zero fill
  input  logic [dpwp_pkg::IN_W-1:0]      s_tdata,
  // opcode
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // point_x, point_y, point_z, blue_out, green_out, red_out
  output logic [dpwp_pkg::OUT_W-1:0]     m_tdata,
  input  logic                           cfg_we,
  input  logic [dpwp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dpwp_pkg::CFG_W-1:0]     cfg_data
);

  dpwp_pkg::cfg_t  cfg;
  dpwp_pkg::item_t f_item;
  dpwp_pkg::item_t q_item;
  logic            q_full;
  logic            q_push;
  logic            q_valid;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inv_fx <= dpwp_pkg::RST_INV_FX;
      cfg.inv_fy <= dpwp_pkg::RST_INV_FY;
      cfg.cx     <= dpwp_pkg::RST_CX;
      cfg.cy     <= dpwp_pkg::RST_CY;
      cfg.cutoff <= dpwp_pkg::RST_CUTOFF;
    end else if (cfg_we) begin
      unique case (dpwp_pkg::reg_idx_t'(cfg_index))
        dpwp_pkg::REG_INV_FX: cfg.inv_fx <= cfg_data;
        dpwp_pkg::REG_INV_FY: cfg.inv_fy <= cfg_data;
        dpwp_pkg::REG_CX:     cfg.cx     <= cfg_data[23:0];
        dpwp_pkg::REG_CY:     cfg.cy     <= cfg_data[23:0];
        dpwp_pkg::REG_CUTOFF: cfg.cutoff <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  dpwp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cutoff   (cfg.cutoff),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (f_item)
  );

  dpwp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_item)
  );

  dpwp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
